@@ hdl/plh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the playhead loop accumulator.
// No dependencies; every other file depends on this package.
package plh_pkg;

  localparam int unsigned INDEX_BITS_DEF    = 16;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned STEP_W     = 17;
  localparam int unsigned POS_W      = 32;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT   = 3'd0,
    CFG_STEP_INC    = 3'd1,
    CFG_PAUSED      = 3'd2,
    CFG_LOOP_ENABLE = 3'd3,
    CFG_LOOP_BEGIN  = 3'd4,
    CFG_LOOP_END    = 3'd5,
    CFG_INTERP_ROWS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ROW_W-1:0]  row_count;
    logic [STEP_W-1:0] step_increment;
    logic              paused;
    logic              loop_enable;
    logic [POS_W-1:0]  loop_begin;
    logic [POS_W-1:0]  loop_end;
    logic              interpolate_rows;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [ROW_W-1:0] next_row_index;
    logic [ROW_W-1:0] fraction;
    logic [POS_W-1:0] play_position;
    logic             stepped;
    logic             reload_row;
  } res_t;

endpackage

@@ hdl/plh_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the playhead input and result items.
// Depends on plh_pkg for field widths.
interface plh_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [plh_pkg::POS_W-1:0] new_position;

  modport source (output valid, output op, output new_position, input ready);
  modport sink (input valid, input op, input new_position, output ready);
endinterface

interface plh_out_if;
  logic                     valid;
  logic                     ready;
  logic [plh_pkg::ROW_W-1:0] row_index;
  logic [plh_pkg::ROW_W-1:0] next_row_index;
  logic [plh_pkg::ROW_W-1:0] fraction;
  logic [plh_pkg::POS_W-1:0] play_position;
  logic                     stepped;
  logic                     reload_row;

  modport source (output valid, output row_index, output next_row_index, output fraction,
                  output play_position, output stepped, output reload_row, input ready);
  modport sink (input valid, input row_index, input next_row_index, input fraction,
                input play_position, input stepped, input reload_row, output ready);
endinterface

@@ hdl/plh_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file, written through a plain index/data port.
// Depends on plh_pkg.
module plh_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output plh_pkg::cfg_t                  cfg_o
);
  import plh_pkg::*;

  localparam cfg_t CFG_RESET = '{row_count: '0, step_increment: STEP_W'(1), paused: 1'b1,
                                 loop_enable: 1'b0, loop_begin: '0, loop_end: '0,
                                 interpolate_rows: 1'b0};

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_COUNT:   cfg_d.row_count        = cfg_wdata_i[ROW_W-1:0];
        CFG_STEP_INC:    cfg_d.step_increment   = cfg_wdata_i[STEP_W-1:0];
        CFG_PAUSED:      cfg_d.paused           = cfg_wdata_i[0];
        CFG_LOOP_ENABLE: cfg_d.loop_enable      = cfg_wdata_i[0];
        CFG_LOOP_BEGIN:  cfg_d.loop_begin       = cfg_wdata_i[POS_W-1:0];
        CFG_LOOP_END:    cfg_d.loop_end         = cfg_wdata_i[POS_W-1:0];
        CFG_INTERP_ROWS: cfg_d.interpolate_rows = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/plh_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one item: set, carry, loop clamp, reload flag,
// increment. Pure combinational; depends on plh_pkg.
module plh_step #(
  parameter int unsigned INDEX_BITS    = plh_pkg::INDEX_BITS_DEF,
  parameter int unsigned FRACTION_BITS = plh_pkg::FRACTION_BITS_DEF
) (
  input  plh_pkg::cfg_t                 cfg_i,
  input  logic                          op_i,
  input  logic [plh_pkg::POS_W-1:0]     new_position_i,
  input  logic [INDEX_BITS-1:0]         row_i,
  input  logic [FRACTION_BITS:0]        frac_i,
  input  logic                          stale_i,
  output logic [INDEX_BITS-1:0]         row_o,
  output logic [FRACTION_BITS:0]        frac_o,
  output logic                          stale_o,
  output plh_pkg::res_t                 res_o
);
  import plh_pkg::*;

  // Wide enough for any position, the loop registers and the carry.
  localparam int unsigned W = INDEX_BITS + FRACTION_BITS + POS_W + 2;
  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned FB = FRACTION_BITS;

  logic [W-1:0]    set_ext, lb_ext, carry_nxt, pos1, one_ext, inc_ext, inc_sat, frac_sum;
  logic [W-1:0]    rep_nxt, rep_pos;
  logic [IB-1:0]   set_row, r1, r2, rep_row;
  logic [FB:0]     f1, f2, rep_frac;
  logic [W-1:0]    rep_frac_lo;
  logic            carry, stale1, stale3, out_loop, reload, stepped;

  always_comb begin
    // Tick path: carry a whole unit into the row.
    carry     = frac_i[FB];
    carry_nxt = W'(row_i) + W'(1);
    if (carry_nxt >= W'(cfg_i.row_count)) begin
      carry_nxt = '0;
    end
    r1     = carry ? carry_nxt[IB-1:0] : row_i;
    f1     = {1'b0, frac_i[FB-1:0]};
    stale1 = stale_i | carry;

    // Loop clamp against the full-width position.
    pos1     = (W'(r1) << FB) | W'(f1[FB-1:0]);
    lb_ext   = W'(cfg_i.loop_begin);
    out_loop = cfg_i.loop_enable && (cfg_i.loop_begin != cfg_i.loop_end) &&
               ((pos1 > W'(cfg_i.loop_end)) || (pos1 < lb_ext));
    r2 = out_loop ? lb_ext[FB +: IB] : r1;
    f2 = out_loop ? {1'b0, cfg_i.loop_begin[FB-1:0]} : f1;

    stale3  = stale1 | out_loop | cfg_i.interpolate_rows;
    reload  = stale3 && (cfg_i.row_count != '0);

    one_ext  = W'(1) << FB;
    inc_ext  = W'(cfg_i.step_increment);
    inc_sat  = (inc_ext > one_ext) ? one_ext : inc_ext;
    frac_sum = W'(f2) + inc_sat;

    set_ext = W'(new_position_i);
    set_row = set_ext[FB +: IB];

    stepped  = 1'b0;
    rep_row  = row_i;
    rep_frac = frac_i;
    row_o    = row_i;
    frac_o   = frac_i;
    stale_o  = stale_i;
    if (op_i == OP_SET) begin
      row_o    = set_row;
      frac_o   = {1'b0, new_position_i[FB-1:0]};
      stale_o  = stale_i | (set_row != row_i);
      rep_row  = row_o;
      rep_frac = frac_o;
      reload   = 1'b0;
    end else if (cfg_i.paused) begin
      reload   = 1'b0;  // held; a pending carry shows in the position only
    end else begin
      stepped  = carry;
      rep_row  = r2;
      rep_frac = f2;
      row_o    = r2;
      frac_o   = frac_sum[FB:0];
      stale_o  = stale3 & ~reload;
    end

    rep_nxt = W'(rep_row) + W'(1);
    if (rep_nxt >= W'(cfg_i.row_count)) begin
      rep_nxt = '0;
    end
    rep_pos     = (W'(rep_row) << FB) + W'(rep_frac);
    rep_frac_lo = W'(rep_frac[FB-1:0]);

    res_o.row_index      = ROW_W'(W'(rep_row));
    res_o.next_row_index = rep_nxt[ROW_W-1:0];
    res_o.fraction       = rep_frac_lo[ROW_W-1:0];
    res_o.play_position  = rep_pos[POS_W-1:0];
    res_o.stepped        = stepped;
    res_o.reload_row     = reload;
  end

endmodule

@@ hdl/playhead_loop_accumulator.sv @@
`timescale 1ns / 1ps
// Playhead loop accumulator top level: input register, playhead state,
// result register. Depends on plh_pkg, plh_if, plh_cfg_regs, plh_step.
//
// Usage: one input item per audio sample on in_i (op = tick) or to jump the
// playhead (op = set, new_position in Q16.16). Every item yields exactly one
// result item on out_o: row, next row, fraction, position, stepped and
// reload_row flags. Registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while no item is in flight.
// Path: an accepted item goes into the input register, then through one pass
// of the step logic into the result register.
// Throughput: 1 item per cycle while out_o.ready is high; the state update is
// a few adds, compares and muxes between the state registers.
// Reset: playhead at row 0, fraction 0, paused, step 1, loop off.
// Stall: while out_o.ready is low the result holds; one more item may wait
// in the input register, after which in_i.ready drops.
module playhead_loop_accumulator #(
  parameter int unsigned INDEX_BITS    = plh_pkg::INDEX_BITS_DEF,
  parameter int unsigned FRACTION_BITS = plh_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  plh_in_if.sink                         in_i,
  plh_out_if.source                      out_o
);
  import plh_pkg::*;

  cfg_t cfg;

  logic                     in_valid_q;
  logic                     in_op_q;
  logic [POS_W-1:0]         in_pos_q;
  logic [INDEX_BITS-1:0]    row_q, row_d;
  logic [FRACTION_BITS:0]   frac_q, frac_d;
  logic                     stale_q, stale_d;
  logic                     out_valid_q;
  res_t                     res_q, res_d;
  logic                     advance, in_take;

  plh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  plh_step #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step (
    .cfg_i          (cfg),
    .op_i           (in_op_q),
    .new_position_i (in_pos_q),
    .row_i          (row_q),
    .frac_i         (frac_q),
    .stale_i        (stale_q),
    .row_o          (row_d),
    .frac_o         (frac_d),
    .stale_o        (stale_d),
    .res_o          (res_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= in_i.op;
      in_pos_q <= in_i.new_position;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      frac_q  <= '0;
      stale_q <= 1'b0;
    end else if (advance) begin
      row_q   <= row_d;
      frac_q  <= frac_d;
      stale_q <= stale_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.row_index      = res_q.row_index;
  assign out_o.next_row_index = res_q.next_row_index;
  assign out_o.fraction       = res_q.fraction;
  assign out_o.play_position  = res_q.play_position;
  assign out_o.stepped        = res_q.stepped;
  assign out_o.reload_row     = res_q.reload_row;

`ifndef SYNTHESIS
  a_reload_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.reload_row |-> cfg.row_count != '0)
    else $error("reload_row with no rows loaded");

  a_step_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.stepped && (cfg.row_count != '0) |-> res_q.reload_row)
    else $error("row step without reload");

  a_next_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.next_row_index == '0) ||
                    (res_q.next_row_index == ROW_W'(res_q.row_index + ROW_W'(1))))
    else $error("next_row_index neither wrap nor row + 1");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(row_q) && $stable(frac_q) && $stable(stale_q))
    else $error("playhead state moved without an item");
`endif

endmodule
